[design/chained_tag_hash_table_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the chained tag hash table
// Wrap concurrent checks clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef CHAINED_TAG_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_TAG_HASH_TABLE_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define CTH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define CTH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cth_pkg.sv]
// ---------------------------------------------------------------------------
// cth_pkg
// Shared codes, widths and types of the chained tag hash table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cth_pkg;

    localparam int BUCKETS_DEF  = 4096;
    localparam int CAPACITY_DEF = 4096;

    localparam int TAG_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int INDEX_W     = 12;
    localparam int KIND_W      = 3;
    localparam int MAX_BKT_W   = 16;
    localparam int MAX_CNT_W   = 17;
    localparam int MOD_DIGITS  = 4;
    localparam int QUEUE_DEPTH = 2;

    // Item kinds as they arrive on the input beat
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

    // Classified operations handed to the back end
    localparam logic [KIND_W-1:0] OP_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] OP_CHECK  = 3'd1;
    localparam logic [KIND_W-1:0] OP_FIND   = 3'd2;
    localparam logic [KIND_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [KIND_W-1:0] OP_READ   = 3'd4;
    localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd5;
    localparam logic [KIND_W-1:0] OP_NONE   = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]         op;
        logic signed [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0]        value;
        logic [INDEX_W-1:0]        index;
        logic [MAX_BKT_W-1:0]      bucket;
    } cmd_t;

    typedef struct packed {
        logic                 init_busy;
        logic [MAX_CNT_W-1:0] count;
    } status_t;

endpackage

[design/cth_front.sv]
// ---------------------------------------------------------------------------
// cth_front
// Accept input beats, classify them and derive the bucket of the tag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cth_front #(
    parameter int BUCKETS = cth_pkg::BUCKETS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cth_pkg::KIND_W-1:0]        kind,
    input  logic signed [cth_pkg::TAG_W-1:0]  key_tag,
    input  logic [cth_pkg::VALUE_W-1:0]       entry_value,
    input  logic [cth_pkg::INDEX_W-1:0]       entry_index,
    input  logic                              init_busy,
    output cth_pkg::cmd_t                     cmd,
    output logic                              cmd_valid,
    input  logic                              cmd_ready
);
    import cth_pkg::*;

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int NSTEP = TAG_W / MOD_DIGITS;
    localparam int SW    = $clog2(NSTEP + 1);

    logic                    hold_reg;
    logic [KIND_W-1:0]       op_reg, op_in;
    logic signed [TAG_W-1:0] tag_reg;
    logic [VALUE_W-1:0]      val_reg;
    logic [INDEX_W-1:0]      idx_reg;
    logic                    in_fire, push, tag_ok, val_ok, mod_done;
    logic [BW-1:0]           bucket_w;

    assign in_ready = !hold_reg && !init_busy;
    assign in_fire  = in_valid && in_ready;
    assign push     = cmd_valid && cmd_ready;
    assign tag_ok   = (key_tag != '0) && (key_tag != -32'sd1);
    assign val_ok   = entry_value != '0;

    always_comb
    begin
        unique case (kind)
            KIND_INSERT: op_in = (tag_ok && val_ok) ? OP_INSERT : OP_NONE;
            KIND_CHECK:  op_in = (tag_ok && val_ok) ? OP_CHECK : OP_NONE;
            KIND_FIND:   op_in = tag_ok ? OP_FIND : OP_NONE;
            KIND_NEXT:   op_in = tag_ok ? OP_NEXT : OP_NONE;
            KIND_READ:   op_in = OP_READ;
            KIND_CLEAR:  op_in = OP_CLEAR;
            default:     op_in = OP_NONE;
        endcase
    end

    generate
        if (POW2)
        begin : g_mask
            // power-of-two table: take the low tag bits
            assign bucket_w = tag_reg[BW-1:0];
            assign mod_done = 1'b1;
        end
        else
        begin : g_rem
            localparam logic [BW:0] BKT_C = (BW + 1)'(BUCKETS);

            logic [BW-1:0]    rem_reg, rem_next;
            logic [TAG_W-1:0] bits_reg, bits_next;
            logic [SW-1:0]    step_reg, step_next;
            logic [BW:0]      trial;

            // restoring remainder, MOD_DIGITS tag bits per cycle
            always_comb
            begin
                rem_next = rem_reg;
                trial    = '0;
                for (int i = 0; i < MOD_DIGITS; i++)
                begin
                    trial = {rem_next, bits_reg[TAG_W-1-i]};
                    if (trial >= BKT_C)
                    begin
                        trial = trial - BKT_C;
                    end
                    rem_next = trial[BW-1:0];
                end
                bits_next = bits_reg << MOD_DIGITS;
                step_next = step_reg + 1'b1;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    step_reg <= '0;
                end
                else if (in_fire)
                begin
                    step_reg <= '0;
                end
                else if (hold_reg && !mod_done)
                begin
                    step_reg <= step_next;
                end
            end

            always_ff @(posedge clk)
            begin
                if (in_fire)
                begin
                    rem_reg  <= '0;
                    bits_reg <= key_tag;
                end
                else if (hold_reg && !mod_done)
                begin
                    rem_reg  <= rem_next;
                    bits_reg <= bits_next;
                end
            end

            assign mod_done = step_reg == SW'(NSTEP);
            assign bucket_w = rem_reg;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            hold_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op_in;
            tag_reg <= key_tag;
            val_reg <= entry_value;
            idx_reg <= entry_index;
        end
    end

    assign cmd_valid  = hold_reg && mod_done;
    assign cmd.op     = op_reg;
    assign cmd.tag    = tag_reg;
    assign cmd.value  = val_reg;
    assign cmd.index  = idx_reg;
    assign cmd.bucket = MAX_BKT_W'(bucket_w);

endmodule

[design/cth_queue.sv]
// ---------------------------------------------------------------------------
// cth_queue
// Short command queue between the front and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cth_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  cth_pkg::cmd_t push_cmd,
    input  logic          push_valid,
    output logic          push_ready,
    output cth_pkg::cmd_t pop_cmd,
    output logic          pop_valid,
    input  logic          pop_ready
);
    import cth_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [FW-1:0] fill_reg;
    logic          do_push, do_pop;

    assign push_ready = fill_reg != FW'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

[design/cth_back.sv]
// ---------------------------------------------------------------------------
// cth_back
// Hold the head table and entry store; walk chains and drive the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cth_back #(
    parameter int BUCKETS  = cth_pkg::BUCKETS_DEF,
    parameter int CAPACITY = cth_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cth_pkg::cmd_t                     cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    output cth_pkg::status_t                  status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [cth_pkg::INDEX_W-1:0]       result_index,
    output logic signed [cth_pkg::TAG_W-1:0]  result_tag,
    output logic [cth_pkg::VALUE_W-1:0]       result_value,
    output logic                              store_full
);
    import cth_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = IW + 1;
    localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLEAR  = 4'd2;
    localparam logic [3:0] S_HEAD   = 4'd3;
    localparam logic [3:0] S_LINK   = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_READ   = 4'd6;
    localparam logic [3:0] S_LINKWR = 4'd7;

    logic [3:0]    state_reg, state_next;
    logic [BW-1:0] ptr_reg, ptr_next;
    cmd_t          cmd_reg, cmd_next;
    logic [IW-1:0] cur_reg, cur_next, last_reg, last_next;
    logic [CW-1:0] count_reg, count_next;

    // head table: valid bit and entry index
    logic [IW:0]   head_mem [BUCKETS];
    logic [IW:0]   head_rd, head_wd;
    logic          head_we;
    logic [BW-1:0] head_wa, head_ra;

    // entry store
    logic signed [TAG_W-1:0] tag_mem [CAPACITY];
    logic [VALUE_W-1:0]      val_mem [CAPACITY];
    logic [IW:0]             link_mem [CAPACITY];
    logic signed [TAG_W-1:0] tag_rd;
    logic [VALUE_W-1:0]      val_rd;
    logic [IW:0]             link_rd, lk_wd;
    logic                    tv_we, lk_we;
    logic [IW-1:0]           tv_wa, lk_wa, ent_ra;

    logic                    out_valid_reg, found_reg, full_reg;
    logic [INDEX_W-1:0]      ridx_reg;
    logic signed [TAG_W-1:0] rtag_reg;
    logic [VALUE_W-1:0]      rval_reg;

    logic                    emit, e_found, e_full;
    logic [IW-1:0]           e_idx;
    logic signed [TAG_W-1:0] e_tag;
    logic [VALUE_W-1:0]      e_val;
    logic                    miss_end, miss_any;
    logic [IW-1:0]           miss_last;

    logic [BW-1:0] bkt;
    logic [IW-1:0] cidx_in;
    logic          in_range_in, head_ok, link_ok, match, full;

    assign bkt         = cmd_reg.bucket[BW-1:0];
    assign cidx_in     = IW'(cmd.index);
    assign in_range_in = WW'(cmd.index) < WW'(count_reg);
    assign head_ok     = head_rd[IW] && ({1'b0, head_rd[IW-1:0]} < count_reg);
    assign link_ok     = link_rd[IW] && ({1'b0, link_rd[IW-1:0]} < count_reg);
    assign full        = count_reg >= CW'(CAPACITY);
    assign match       = (tag_rd == cmd_reg.tag)
                      && (cmd_reg.op == OP_FIND || cmd_reg.op == OP_NEXT
                          || val_rd == cmd_reg.value);

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        count_next = count_reg;
        cmd_ready  = 1'b0;
        head_we    = 1'b0;
        head_wa    = bkt;
        head_wd    = '0;
        head_ra    = cmd.bucket[BW-1:0];
        tv_we      = 1'b0;
        tv_wa      = count_reg[IW-1:0];
        lk_we      = 1'b0;
        lk_wa      = count_reg[IW-1:0];
        lk_wd      = '0;
        ent_ra     = cidx_in;
        emit       = 1'b0;
        e_found    = 1'b0;
        e_full     = 1'b0;
        e_idx      = cur_reg;
        e_tag      = tag_rd;
        e_val      = val_rd;
        miss_end   = 1'b0;
        miss_any   = 1'b0;
        miss_last  = last_reg;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = ptr_reg;
                if (ptr_reg == BW'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || out_ready))
                begin
                    cmd_ready = 1'b1;
                    cmd_next  = cmd;
                    unique case (cmd.op)
                        OP_INSERT, OP_CHECK, OP_FIND:
                        begin
                            state_next = S_HEAD;
                        end
                        OP_NEXT:
                        begin
                            if (in_range_in)
                            begin
                                state_next = S_LINK;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (in_range_in)
                            begin
                                cur_next   = cidx_in;
                                state_next = S_READ;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                            emit       = 1'b1;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                emit       = 1'b1;
                e_found    = 1'b1;
                state_next = S_IDLE;
            end
            S_LINK:
            begin
                if (link_ok)
                begin
                    ent_ra     = link_rd[IW-1:0];
                    cur_next   = link_rd[IW-1:0];
                    state_next = S_WALK;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_HEAD:
            begin
                if (head_ok)
                begin
                    ent_ra     = head_rd[IW-1:0];
                    cur_next   = head_rd[IW-1:0];
                    state_next = S_WALK;
                end
                else
                begin
                    miss_end = 1'b1;
                end
            end
            S_WALK:
            begin
                if (match)
                begin
                    emit       = 1'b1;
                    e_found    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    last_next = cur_reg;
                    if (link_ok)
                    begin
                        ent_ra   = link_rd[IW-1:0];
                        cur_next = link_rd[IW-1:0];
                    end
                    else
                    begin
                        miss_end  = 1'b1;
                        miss_any  = 1'b1;
                        miss_last = cur_reg;
                    end
                end
            end
            S_LINKWR:
            begin
                lk_we      = 1'b1;
                lk_wa      = last_reg;
                lk_wd      = {1'b1, cur_reg};
                emit       = 1'b1;
                e_found    = 1'b1;
                e_tag      = cmd_reg.tag;
                e_val      = cmd_reg.value;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a chain with no match: append on insert unless the store is full, else answer a miss
        if (miss_end)
        begin
            state_next = S_IDLE;
            if (cmd_reg.op == OP_INSERT && !full)
            begin
                tv_we      = 1'b1;
                lk_we      = 1'b1;
                count_next = count_reg + 1'b1;
                cur_next   = count_reg[IW-1:0];
                if (miss_any)
                begin
                    last_next  = miss_last;
                    state_next = S_LINKWR;
                end
                else
                begin
                    head_we = 1'b1;
                    head_wd = {1'b1, count_reg[IW-1:0]};
                    emit    = 1'b1;
                    e_found = 1'b1;
                    e_idx   = count_reg[IW-1:0];
                    e_tag   = cmd_reg.tag;
                    e_val   = cmd_reg.value;
                end
            end
            else
            begin
                emit   = 1'b1;
                e_full = cmd_reg.op == OP_INSERT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ptr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        cur_reg  <= cur_next;
        last_reg <= last_next;
        if (emit)
        begin
            found_reg <= e_found;
            full_reg  <= e_full;
            ridx_reg  <= e_found ? INDEX_W'(e_idx) : '0;
            rtag_reg  <= e_found ? e_tag : -32'sd1;
            rval_reg  <= e_found ? e_val : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tv_we)
        begin
            tag_mem[tv_wa] <= cmd_reg.tag;
            val_mem[tv_wa] <= cmd_reg.value;
        end
        if (lk_we)
        begin
            link_mem[lk_wa] <= lk_wd;
        end
        tag_rd  <= tag_mem[ent_ra];
        val_rd  <= val_mem[ent_ra];
        link_rd <= link_mem[ent_ra];
    end

    assign status.init_busy = state_reg == S_INIT;
    assign status.count     = MAX_CNT_W'(count_reg);

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign result_index = ridx_reg;
    assign result_tag   = rtag_reg;
    assign result_value = rval_reg;
    assign store_full   = full_reg;

endmodule

[design/chained_tag_hash_table_top.sv]
// ---------------------------------------------------------------------------
// chained_tag_hash_table_top: multimap from 32-bit tags to nonzero values
// Path: the front registers the beat (and works out the tag remainder when
//   BUCKETS is not a power of two), the queue passes it to the back end,
//   which reads the head and then visits one chain entry per cycle; a fresh
//   insert behind a chain adds a link write.
// Occupancy: one item at a time in the back end, set by the chain walk on
//   the single entry-store read port; a clear occupies it for its head sweep.
// Reset: the head table is swept with in_ready held low.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "chained_tag_hash_table_top_assert.svh"

module chained_tag_hash_table_top #(
    parameter int BUCKETS  = cth_pkg::BUCKETS_DEF,
    parameter int CAPACITY = cth_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel: one beat per item
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cth_pkg::KIND_W-1:0]        kind,
    input  logic signed [cth_pkg::TAG_W-1:0]  key_tag,
    input  logic [cth_pkg::VALUE_W-1:0]       entry_value,
    input  logic [cth_pkg::INDEX_W-1:0]       entry_index,
    // output channel: one result beat per item
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [cth_pkg::INDEX_W-1:0]       result_index,
    output logic signed [cth_pkg::TAG_W-1:0]  result_tag,
    output logic [cth_pkg::VALUE_W-1:0]       result_value,
    output logic                              store_full
);
    import cth_pkg::*;

    // Front to queue: classified command with its bucket already worked out
    cmd_t    fq_cmd;
    logic    fq_valid, fq_ready;
    // Queue to back end
    cmd_t    qb_cmd;
    logic    qb_valid, qb_ready;
    // Back-end status: head sweep after reset and current fill of the store
    status_t sts;

    // Front: take a beat, drop invalid tags and values to a plain miss,
    // and reduce the tag to its bucket. Hold off new beats during the
    // reset sweep of the head table.
    cth_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key_tag     (key_tag),
        .entry_value (entry_value),
        .entry_index (entry_index),
        .init_busy   (sts.init_busy),
        .cmd         (fq_cmd),
        .cmd_valid   (fq_valid),
        .cmd_ready   (fq_ready)
    );

    // Queue: decouple the front from a long chain walk or clear sweep
    cth_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (fq_cmd),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .pop_cmd    (qb_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready)
    );

    // Back end: own the memories, walk chains one entry per cycle, append
    // new entries to the chain tail, and hold each result in the output
    // register until the beat is taken.
    cth_back #(
        .BUCKETS  (BUCKETS),
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (qb_cmd),
        .cmd_valid    (qb_valid),
        .cmd_ready    (qb_ready),
        .status       (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .result_index (result_index),
        .result_tag   (result_tag),
        .result_value (result_value),
        .store_full   (store_full)
    );

    // A miss carries the neutral index, tag and value
    `CTH_ASSERT_NOW(a_miss_fields, out_valid && !found, result_index == '0 && result_tag == -32'sd1 && result_value == '0, "miss result carries entry data")
    // A dropped insert is never reported as found
    `CTH_ASSERT_NOW(a_full_is_miss, out_valid && store_full, !found, "full store reported with a hit")
    // The store never fills past its capacity
    `CTH_ASSERT_NOW(a_count_bound, 1'b1, sts.count <= MAX_CNT_W'(CAPACITY), "entry count exceeds capacity")
    // The reset sweep runs once and does not restart
    `CTH_ASSERT_NEXT(a_init_once, !sts.init_busy, !sts.init_busy, "reset sweep restarted")

endmodule

[dv/cth_answer_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cth_answer_checker: answer prediction and comparison for the hash table
// Mirrors the head table, entry store and fill level, predicts one answer
// per accepted input beat and compares each output beat in order.
// ---------------------------------------------------------------------------

module cth_answer_checker #(
    parameter int BUCKETS  = cth_pkg::BUCKETS_DEF,
    parameter int CAPACITY = cth_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [cth_pkg::KIND_W-1:0]        kind,
    input  logic signed [cth_pkg::TAG_W-1:0]  key_tag,
    input  logic [cth_pkg::VALUE_W-1:0]       entry_value,
    input  logic [cth_pkg::INDEX_W-1:0]       entry_index,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              found,
    input  logic [cth_pkg::INDEX_W-1:0]       result_index,
    input  logic signed [cth_pkg::TAG_W-1:0]  result_tag,
    input  logic [cth_pkg::VALUE_W-1:0]       result_value,
    input  logic                              store_full,
    output int                                fail_count,
    output int                                pending_results,
    output int                                answers_checked,
    output int                                full_drops
);

    import cth_pkg::*;

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  index;
        logic [TAG_W-1:0]    tag;
        logic [VALUE_W-1:0]  value;
        logic                full;
    } lookup_answer_t;

    bit               head_used  [BUCKETS];
    int unsigned      head_slot  [BUCKETS];
    logic [TAG_W-1:0] slot_tag   [CAPACITY];
    logic [VALUE_W-1:0] slot_value [CAPACITY];
    bit               slot_linked [CAPACITY];
    int unsigned      slot_link  [CAPACITY];
    int unsigned      fill_level;

    lookup_answer_t   answer_q [$];

    function automatic bit usable_tag(input logic [TAG_W-1:0] t);
        return t != '0 && t != '1;
    endfunction

    // Walk a chain; on a miss, tail holds the last entry visited when visited is set.
    function automatic bit chain_search(input bit start_ok, input int unsigned start,
                                        input logic [TAG_W-1:0] t, input bit match_value,
                                        input logic [VALUE_W-1:0] v,
                                        output int unsigned hit, output int unsigned tail,
                                        output bit visited);
        int unsigned pos;
        int unsigned steps;
        bit more;
        pos     = start;
        more    = start_ok;
        steps   = 0;
        hit     = 0;
        tail    = 0;
        visited = 1'b0;
        while (more && pos < fill_level && steps < CAPACITY)
        begin
            if (slot_tag[pos] == t && (!match_value || slot_value[pos] == v))
            begin
                hit = pos;
                return 1'b1;
            end
            tail    = pos;
            visited = 1'b1;
            more    = slot_linked[pos];
            pos     = slot_link[pos];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic lookup_answer_t make_answer(input bit hit, input int unsigned pos,
                                                   input bit full);
        lookup_answer_t a;
        a.found = hit;
        a.index = hit ? pos[INDEX_W-1:0] : '0;
        a.tag   = hit ? slot_tag[pos] : '1;
        a.value = hit ? slot_value[pos] : '0;
        a.full  = full;
        return a;
    endfunction

    // Apply one item to the mirrored table and return the answer it gives.
    function automatic lookup_answer_t apply_item(input logic [KIND_W-1:0] op,
                                                  input logic [TAG_W-1:0] t,
                                                  input logic [VALUE_W-1:0] v,
                                                  input logic [INDEX_W-1:0] ix);
        int unsigned bucket;
        int unsigned hit;
        int unsigned tail;
        bit visited;
        bit ok;
        bucket = t % BUCKETS;
        case (op)
            KIND_INSERT:
            begin
                if (usable_tag(t) && v != '0)
                begin
                    if (chain_search(head_used[bucket], head_slot[bucket], t, 1'b1, v,
                                     hit, tail, visited))
                        return make_answer(1'b1, hit, 1'b0);
                    if (fill_level >= CAPACITY)
                        return make_answer(1'b0, 0, 1'b1);
                    hit              = fill_level;
                    slot_tag[hit]    = t;
                    slot_value[hit]  = v;
                    slot_linked[hit] = 1'b0;
                    slot_link[hit]   = 0;
                    if (visited)
                    begin
                        slot_linked[tail] = 1'b1;
                        slot_link[tail]   = hit;
                    end
                    else
                    begin
                        head_used[bucket] = 1'b1;
                        head_slot[bucket] = hit;
                    end
                    fill_level++;
                    return make_answer(1'b1, hit, 1'b0);
                end
            end
            KIND_CHECK:
            begin
                if (usable_tag(t) && v != '0)
                begin
                    ok = chain_search(head_used[bucket], head_slot[bucket], t, 1'b1, v,
                                      hit, tail, visited);
                    return make_answer(ok, hit, 1'b0);
                end
            end
            KIND_FIND:
            begin
                if (usable_tag(t))
                begin
                    ok = chain_search(head_used[bucket], head_slot[bucket], t, 1'b0, '0,
                                      hit, tail, visited);
                    return make_answer(ok, hit, 1'b0);
                end
            end
            KIND_NEXT:
            begin
                if (usable_tag(t) && ix < fill_level)
                begin
                    ok = chain_search(slot_linked[ix], slot_link[ix], t, 1'b0, '0,
                                      hit, tail, visited);
                    return make_answer(ok, hit, 1'b0);
                end
            end
            KIND_READ:
            begin
                if (ix < fill_level)
                    return make_answer(1'b1, ix, 1'b0);
            end
            KIND_CLEAR:
            begin
                foreach (head_used[b])
                    head_used[b] = 1'b0;
                fill_level = 0;
            end
            default:
            begin
            end
        endcase
        return make_answer(1'b0, 0, 1'b0);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: answer %0d, %s: expected 0x%08h, got 0x%08h",
                 $time, answers_checked, field, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_answer_t want;
        if (!rst_n)
        begin
            answer_q.delete();
            foreach (head_used[b])
                head_used[b] = 1'b0;
            fill_level      = 0;
            fail_count      = 0;
            answers_checked = 0;
            full_drops      = 0;
            pending_results <= 0;
        end
        else
        begin
            // retire the output beat first: it always belongs to an older item
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                    report_mismatch("result beat with nothing outstanding", 32'd0, 32'd1);
                else
                begin
                    want = answer_q.pop_front();
                    if (found !== want.found)
                        report_mismatch("found", 32'(want.found), 32'(found));
                    if (result_index !== want.index)
                        report_mismatch("result_index", 32'(want.index), 32'(result_index));
                    if (result_tag !== want.tag)
                        report_mismatch("result_tag", want.tag, result_tag);
                    if (result_value !== want.value)
                        report_mismatch("result_value", want.value, result_value);
                    if (store_full !== want.full)
                        report_mismatch("store_full", 32'(want.full), 32'(store_full));
                    if (want.full)
                        full_drops++;
                    answers_checked++;
                end
            end
            if (in_valid && in_ready)
                answer_q.push_back(apply_item(kind, key_tag, entry_value, entry_index));
            pending_results <= answer_q.size();
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the chained tag hash table
// Drives directed corner items, then random episodes (each opened by a
// clear, some of them filling the entry store) under three handshake
// pressure patterns; the answer checker predicts and compares every beat.
// ---------------------------------------------------------------------------

module tb_top;

    import cth_pkg::*;

    // A small entry store so that fill-ups and full-store drops come often;
    // the head table keeps its full size so the tag remainder is the real one.
    localparam int TB_BUCKETS    = BUCKETS_DEF;
    localparam int TB_CAPACITY   = 128;
    localparam int FILL_ITEMS    = TB_CAPACITY + TB_CAPACITY / 4 + 16;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 200;
    localparam int RUN_LIMIT     = 3_000_000;

    // Kinds the block decodes as no operation
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Directed tags: two tags sharing bucket 1 to build a chain
    localparam logic [TAG_W-1:0] TAG_CHAIN_A = 32'h0000_1001;
    localparam logic [TAG_W-1:0] TAG_CHAIN_B = 32'h8000_1001;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [KIND_W-1:0]          kind = KIND_INSERT;
    logic signed [TAG_W-1:0]    key_tag = '0;
    logic [VALUE_W-1:0]         entry_value = '0;
    logic [INDEX_W-1:0]         entry_index = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic                       found;
    logic [INDEX_W-1:0]         result_index;
    logic signed [TAG_W-1:0]    result_tag;
    logic [VALUE_W-1:0]         result_value;
    logic                       store_full;

    int fail_count;
    int pending_results;
    int answers_checked;
    int full_drops;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int fill_runs = 0;
    int kind_tally [8];

    // Pairs inserted since the last clear, kept only to steer the stimulus
    logic [TAG_W-1:0]   live_tags   [$];
    logic [VALUE_W-1:0] live_values [$];

    always #5 clk = ~clk;

    chained_tag_hash_table_top #(
        .BUCKETS  (TB_BUCKETS),
        .CAPACITY (TB_CAPACITY)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key_tag      (key_tag),
        .entry_value  (entry_value),
        .entry_index  (entry_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .result_index (result_index),
        .result_tag   (result_tag),
        .result_value (result_value),
        .store_full   (store_full)
    );

    cth_answer_checker #(
        .BUCKETS  (TB_BUCKETS),
        .CAPACITY (TB_CAPACITY)
    ) answer_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .key_tag         (key_tag),
        .entry_value     (entry_value),
        .entry_index     (entry_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .result_index    (result_index),
        .result_tag      (result_tag),
        .result_value    (result_value),
        .store_full      (store_full),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .answers_checked (answers_checked),
        .full_drops      (full_drops)
    );

    // Receiver: stall at random on the falling edge, per the current phase
    always @(negedge clk)
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);

    // Present one beat, hold it until accepted, and return on the next
    // falling edge. Valid is only lowered for an idle gap, never toggled
    // between back-to-back beats.
    task automatic send_item(input logic [KIND_W-1:0] op, input logic [TAG_W-1:0] t,
                             input logic [VALUE_W-1:0] v, input logic [INDEX_W-1:0] ix);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        kind        = op;
        key_tag     = t;
        entry_value = v;
        entry_index = ix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
        kind_tally[op]++;
        if (op == KIND_CLEAR)
        begin
            live_tags.delete();
            live_values.delete();
        end
        else if (op == KIND_INSERT && t != '0 && t != '1 && v != '0)
        begin
            live_tags.push_back(t);
            live_values.push_back(v);
        end
    endtask

    // One random item. Most are well formed and many aim at pairs already in the
    // table; a few are pure noise across every field.
    task automatic random_item(input bit fill_mode);
        int unsigned roll;
        int unsigned est;
        int unsigned pick;
        int unsigned reuse_pct;
        logic [KIND_W-1:0]  op;
        logic [TAG_W-1:0]   t;
        logic [VALUE_W-1:0] v;
        logic [INDEX_W-1:0] ix;
        roll = $urandom_range(0, 99);
        if (roll < 6)
        begin
            send_item(3'($urandom_range(0, 7)), $urandom(), $urandom(),
                      12'($urandom_range(0, 4095)));
            return;
        end
        est  = (live_tags.size() < TB_CAPACITY) ? live_tags.size() : TB_CAPACITY;
        roll = $urandom_range(0, 99);
        // a fill run is mostly inserts; fold the rest onto the lookup kinds and a spare kind
        if (fill_mode)
            roll = (roll < 85) ? 0 : 40 + (roll - 85) * 4;
        if (roll < 40)
            op = KIND_INSERT;
        else if (roll < 55)
            op = KIND_CHECK;
        else if (roll < 70)
            op = KIND_FIND;
        else if (roll < 84)
            op = KIND_NEXT;
        else if (roll < 96)
            op = KIND_READ;
        else if (roll < 97)
            op = KIND_SPARE_LO;
        else if (roll < 98)
            op = KIND_SPARE_HI;
        else
            op = KIND_CLEAR;

        if (op == KIND_INSERT)
            reuse_pct = fill_mode ? 5 : 35;
        else
            reuse_pct = 75;
        if (live_tags.size() != 0 && $urandom_range(0, 99) < reuse_pct)
        begin
            pick = $urandom_range(0, live_tags.size() - 1);
            t    = live_tags[pick];
            v    = live_values[pick];
        end
        else
        begin
            // crowd a handful of buckets so chains grow long
            t = $urandom();
            case ($urandom_range(0, 9))
                0:       t[11:0] = 12'h000;
                1:       t[11:0] = 12'hFFF;
                2, 3:    t[11:0] = 12'h001;
                4, 5:    t[11:0] = 12'h7A5;
                6:       t[11:0] = 12'h800;
                default: ;
            endcase
            // small values give the same tag several entries
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: v = $urandom_range(1, 3);
                5:             v = '1;
                6:             v = '0;
                default:       v = $urandom();
            endcase
        end
        if (est != 0 && $urandom_range(0, 4) != 0)
            ix = 12'($urandom_range(0, est - 1));
        else
            ix = 12'($urandom_range(0, 4095));
        send_item(op, t, v, ix);
    endtask

    // Run random episodes under one pressure pattern. Each episode opens
    // with a clear; the first of the phase fills the store to overflow.
    task automatic run_phase(input int send_pct, input int recv_pct);
        int start;
        int n;
        bit fill;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_sent;
        fill  = 1'b1;
        while (items_sent - start < PHASE_ITEMS)
        begin
            send_item(KIND_CLEAR, $urandom(), $urandom(), 12'($urandom_range(0, 4095)));
            n = fill ? FILL_ITEMS : $urandom_range(20, 70);
            if (fill)
                fill_runs++;
            repeat (n)
                random_item(fill);
            fill = ($urandom_range(0, 5) == 0);
        end
    endtask

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("chained_tag_hash_table_top verification failed");
        $finish;
    end

    initial
    begin
        foreach (kind_tally[k])
            kind_tally[k] = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners, under the first pressure pattern. Invalid tags
        // and a zero value are dropped; then a chain of three entries in
        // bucket 1, the tag extremes, and every lookup kind on that table.
        send_idle_pct = 27;
        recv_idle_pct = 68;
        send_item(KIND_INSERT, 32'h0000_0000, 32'd5, 12'd0);
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'd5, 12'd0);
        send_item(KIND_INSERT, 32'h1234_5001, 32'd0, 12'd0);
        send_item(KIND_INSERT, TAG_CHAIN_A, 32'hFFFF_FFFF, 12'd0);
        send_item(KIND_INSERT, TAG_CHAIN_A, 32'hFFFF_FFFF, 12'd0);    // existing pair
        send_item(KIND_INSERT, TAG_CHAIN_B, 32'd1, 12'd0);
        send_item(KIND_INSERT, TAG_CHAIN_A, 32'h8000_0000, 12'd0);
        send_item(KIND_INSERT, 32'h7FFF_FFFF, 32'd7, 12'd0);
        send_item(KIND_INSERT, 32'hFFFF_FFFE, 32'd9, 12'd0);
        send_item(KIND_CHECK, TAG_CHAIN_A, 32'h8000_0000, 12'd0);
        send_item(KIND_CHECK, TAG_CHAIN_B, 32'd2, 12'd0);
        send_item(KIND_CHECK, 32'h0000_0000, 32'd1, 12'd0);
        send_item(KIND_FIND, TAG_CHAIN_A, 32'd0, 12'd0);
        send_item(KIND_FIND, 32'hFFFF_FFFF, 32'd0, 12'd0);
        send_item(KIND_FIND, 32'h8000_0000, 32'd0, 12'd0);            // empty bucket
        send_item(KIND_NEXT, TAG_CHAIN_A, 32'd0, 12'd0);
        send_item(KIND_NEXT, TAG_CHAIN_A, 32'd0, 12'd2);              // end of chain
        send_item(KIND_NEXT, TAG_CHAIN_A, 32'd0, 12'd4095);           // out of range
        send_item(KIND_READ, 32'd0, 32'd0, 12'd3);
        send_item(KIND_READ, 32'd0, 32'd0, 12'd5);                    // at the fill level
        send_item(KIND_SPARE_LO, TAG_CHAIN_A, 32'd1, 12'd0);
        send_item(KIND_SPARE_HI, TAG_CHAIN_A, 32'd1, 12'd0);
        send_item(KIND_CLEAR, TAG_CHAIN_A, 32'd1, 12'd0);
        send_item(KIND_FIND, TAG_CHAIN_A, 32'd0, 12'd0);              // gone after clear
        send_item(KIND_READ, 32'd0, 32'd0, 12'd0);

        run_phase(27, 68);
        run_phase(68, 27);
        run_phase(0, 0);

        // drain: drop valid, wait out every answer, then watch for strays
        in_valid      = 1'b0;
        recv_idle_pct = 0;
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d inserts, %0d lookups, %0d clears, %0d spare kinds",
                 items_sent, kind_tally[KIND_INSERT],
                 kind_tally[KIND_CHECK] + kind_tally[KIND_FIND] + kind_tally[KIND_NEXT]
                     + kind_tally[KIND_READ],
                 kind_tally[KIND_CLEAR], kind_tally[KIND_SPARE_LO] + kind_tally[KIND_SPARE_HI]);
        $display("Compared %0d answers across three stall patterns; %0d store fill-ups, %0d drops",
                 answers_checked, fill_runs, full_drops);
        if (fail_count == 0)
            $display("chained_tag_hash_table_top verification clean");
        else
            $display("chained_tag_hash_table_top verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/cth_pkg.sv
design/cth_front.sv
design/cth_queue.sv
design/cth_back.sv
design/chained_tag_hash_table_top.sv
dv/cth_answer_checker.sv
dv/tb_top.sv
